/* sv/lcsp_pkg.sv */
// Shared types, constants and helpers for the lane change speed planner.
// Used by every module of the block; depends on nothing else.
package lcsp_pkg;

  // Road geometry and frame timing (positions in 1/16 m)
  localparam int LANE_WIDTH    = 64;
  localparam int FRAME_DIVISOR = 50;

  // Field widths
  localparam int POS_W    = 17;
  localparam int PREV_W   = 6;
  localparam int D_W      = 11;
  localparam int V_W      = 12;
  localparam int GAP_W    = 12;
  localparam int SPD_W    = 16;
  localparam int STEP_W   = 10;
  localparam int LANE_W   = 2;
  localparam int TD_W     = 8;

  // Datapath widths
  localparam int SQ_W     = 2 * V_W;        // vx^2 + vy^2
  localparam int ROOT_W   = SQ_W / 2;       // integer square root
  localparam int PROD_W   = PREV_W + ROOT_W; // prev_points * speed
  localparam int DIVR_W   = 10;             // holds FRAME_DIVISOR
  localparam int RECIP_W  = PROD_W + 1;
  localparam int CHK_W    = PROD_W + 2;     // projected position plus window
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << PROD_W) / FRAME_DIVISOR);

  // Stream layout
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 32;
  localparam int EGO_LSB  = 0;
  localparam int END_LSB  = EGO_LSB + POS_W;
  localparam int PREV_LSB = END_LSB + POS_W;
  localparam int D_LSB    = PREV_LSB + PREV_W;
  localparam int VX_LSB   = D_LSB + D_W;
  localparam int VY_LSB   = VX_LSB + V_W;
  localparam int OS_LSB   = VY_LSB + V_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAP_WINDOW  = 3'd0,
    REG_SPEED_LIMIT = 3'd1,
    REG_MID_SPEED   = 3'd2,
    REG_LOW_SPEED   = 3'd3,
    REG_STEP_SMALL  = 3'd4,
    REG_STEP_MID    = 3'd5,
    REG_STEP_LARGE  = 3'd6
  } cfg_reg_t;

  // Lane codes
  localparam logic [LANE_W-1:0] LANE_LEFT   = 2'd0;
  localparam logic [LANE_W-1:0] LANE_CENTER = 2'd1;
  localparam logic [LANE_W-1:0] LANE_RIGHT  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture input transaction
    logic sq1;      // square vx
    logic root_go;  // add vy^2 and start the square root
    logic mul;      // prev_points * speed
    logic div;      // reciprocal estimate of the projection
    logic upd;      // correct, compare and set occupancy flags
    logic decide;   // lane/speed decision and result load
  } lcsp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic root_done;
    logic out_free;
  } lcsp_sts_t;

  // Lane center offset, 1/16 m, kept to 8 bits
  function automatic logic [TD_W-1:0] target_offset(input logic [LANE_W-1:0] lane);
    logic [9:0] full;
    full = 10'(LANE_WIDTH / 2) + 10'(LANE_WIDTH) * 10'(lane);
    return full[TD_W-1:0];
  endfunction

endpackage

/* sv/lcsp_isqrt.sv */
// Iterative integer square root, one result bit per cycle.
// Depends on lcsp_pkg for widths.
module lcsp_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lcsp_pkg::SQ_W-1:0]  radicand,
  output logic                       done,
  output logic [lcsp_pkg::ROOT_W-1:0] root
);
  import lcsp_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 4;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [SQ_W-1:0]   rad;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              take;

  // Bring down two radicand bits and test the next root bit
  assign rem_sh = {rem[REM_W-3:0], rad[SQ_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[SQ_W-3:0], 2'b00};
      if (take) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* sv/lcsp_datapath.sv */
// Datapath: configuration registers, car report arithmetic, occupancy flags,
// lane/speed decision and output register. Depends on lcsp_pkg, lcsp_isqrt.
module lcsp_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lcsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcsp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [lcsp_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  lcsp_pkg::lcsp_cmd_t               cmd,
  output lcsp_pkg::lcsp_sts_t               sts,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lcsp_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import lcsp_pkg::*;

  // Configuration registers
  logic [GAP_W-1:0]  gap_window;
  logic [SPD_W-1:0]  speed_limit, mid_speed, low_speed;
  logic [STEP_W-1:0] step_small, step_mid, step_large;

  // Planner state
  logic [LANE_W-1:0] lane_reg;
  logic [SPD_W-1:0]  speed_reg;
  logic              ahead_flag, left_flag, right_flag;

  // Captured transaction
  logic [POS_W-1:0]         ego_s, end_s, other_s;
  logic [PREV_W-1:0]        prev_points;
  logic signed [D_W-1:0]    other_d;
  logic signed [V_W-1:0]    other_vx, other_vy;

  // Work registers
  logic [SQ_W-1:0]   sq;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] q_est;

  // Output register fields
  logic [LANE_W-1:0] out_lane;
  logic [TD_W-1:0]   out_td;
  logic [SPD_W-1:0]  out_speed;
  logic              out_ahead, out_left, out_right;

  logic [ROOT_W-1:0] root;
  logic              root_done;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_window  <= GAP_W'(480);
      speed_limit <= SPD_W'(49500);
      mid_speed   <= SPD_W'(30000);
      low_speed   <= SPD_W'(25000);
      step_small  <= STEP_W'(112);
      step_mid    <= STEP_W'(224);
      step_large  <= STEP_W'(336);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAP_WINDOW:  gap_window  <= cfg_data[GAP_W-1:0];
        REG_SPEED_LIMIT: speed_limit <= cfg_data[SPD_W-1:0];
        REG_MID_SPEED:   mid_speed   <= cfg_data[SPD_W-1:0];
        REG_LOW_SPEED:   low_speed   <= cfg_data[SPD_W-1:0];
        REG_STEP_SMALL:  step_small  <= cfg_data[STEP_W-1:0];
        REG_STEP_MID:    step_mid    <= cfg_data[STEP_W-1:0];
        REG_STEP_LARGE:  step_large  <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ego_s       <= s_tdata[EGO_LSB  +: POS_W];
      end_s       <= s_tdata[END_LSB  +: POS_W];
      prev_points <= s_tdata[PREV_LSB +: PREV_W];
      other_d     <= s_tdata[D_LSB    +: D_W];
      other_vx    <= s_tdata[VX_LSB   +: V_W];
      other_vy    <= s_tdata[VY_LSB   +: V_W];
      other_s     <= s_tdata[OS_LSB   +: POS_W];
    end
  end

  // Squares of the velocity components
  logic signed [SQ_W-1:0] vxx, vyy;
  logic [SQ_W-1:0]        sq_sum;
  assign vxx    = other_vx * other_vx;
  assign vyy    = other_vy * other_vy;
  assign sq_sum = sq + $unsigned(vyy);

  always_ff @(posedge clk) begin
    if (cmd.sq1) sq <= $unsigned(vxx);
  end

  lcsp_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_go),
    .radicand (sq_sum),
    .done     (root_done),
    .root     (root)
  );

  // Projection: prev_points * speed / FRAME_DIVISOR via reciprocal
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  logic [PROD_W+DIVR_W-1:0]  back_prod;
  logic [PROD_W-1:0]         div_rem;
  logic [PROD_W-1:0]         q_fix;
  assign recip_prod = (PROD_W+RECIP_W)'(prod) * (PROD_W+RECIP_W)'(RECIP);
  assign back_prod  = (PROD_W+DIVR_W)'(q_est) * (PROD_W+DIVR_W)'(FRAME_DIVISOR);
  assign div_rem    = prod - back_prod[PROD_W-1:0];
  assign q_fix      = q_est + PROD_W'(div_rem >= PROD_W'(FRAME_DIVISOR));

  always_ff @(posedge clk) begin
    if (cmd.mul) prod  <= PROD_W'(prev_points) * PROD_W'(root);
    if (cmd.div) q_est <= recip_prod[PROD_W +: PROD_W];
  end

  // Lane of the other car and window tests
  logic              on_road;
  logic [LANE_W-1:0] other_lane;
  logic [CHK_W-1:0]  chk, ref_pos, gap;
  logic              hit_ahead, hit_near;

  assign on_road = !other_d[D_W-1] && (other_d[D_W-2:0] < (D_W-1)'(3 * LANE_WIDTH));

  always_comb begin
    priority if (other_d[D_W-2:0] < (D_W-1)'(LANE_WIDTH))     other_lane = LANE_LEFT;
    else if (other_d[D_W-2:0] < (D_W-1)'(2 * LANE_WIDTH))     other_lane = LANE_CENTER;
    else                                                      other_lane = LANE_RIGHT;
  end

  assign chk       = CHK_W'(other_s) + CHK_W'(q_fix);
  assign ref_pos   = (prev_points != '0) ? CHK_W'(end_s) : CHK_W'(ego_s);
  assign gap       = CHK_W'(gap_window);
  assign hit_ahead = (chk > ref_pos) && (chk < ref_pos + gap);
  assign hit_near  = (ref_pos < chk + gap) && (chk < ref_pos + gap);

  // Decision for the end of frame
  logic [LANE_W-1:0] lane_n;
  logic [SPD_W-1:0]  speed_n;
  logic [STEP_W-1:0] add;
  logic [SPD_W:0]    speed_sum;

  always_comb begin
    lane_n    = lane_reg;
    speed_n   = speed_reg;
    add       = '0;
    speed_sum = '0;
    if (ahead_flag) begin
      priority if (!left_flag && lane_reg != LANE_LEFT)   lane_n = lane_reg - 2'd1;
      else if (!right_flag && lane_reg != LANE_RIGHT)     lane_n = lane_reg + 2'd1;
      else speed_n = (speed_reg > SPD_W'(step_mid)) ? speed_reg - SPD_W'(step_mid) : '0;
    end else begin
      if ((lane_reg == LANE_RIGHT && !left_flag) || (lane_reg == LANE_LEFT && !right_flag))
        lane_n = LANE_CENTER;
      // a speed in no band keeps its value
      priority if (speed_reg < speed_limit && speed_reg >= mid_speed) add = step_small;
      else if (speed_reg < mid_speed && speed_reg >= low_speed)       add = step_mid;
      else if (speed_reg < low_speed)                                 add = step_large;
      else                                                            add = '0;
      speed_sum = {1'b0, speed_reg} + (SPD_W+1)'(add);
      speed_n   = speed_sum[SPD_W] ? '1 : speed_sum[SPD_W-1:0];
    end
  end

  // Planner state and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_reg   <= LANE_CENTER;
      speed_reg  <= '0;
      ahead_flag <= 1'b0;
      left_flag  <= 1'b0;
      right_flag <= 1'b0;
    end else if (cmd.decide) begin
      lane_reg   <= lane_n;
      speed_reg  <= speed_n;
      ahead_flag <= 1'b0;
      left_flag  <= 1'b0;
      right_flag <= 1'b0;
    end else if (cmd.upd && on_road) begin
      if (other_lane == lane_reg && hit_ahead) ahead_flag <= 1'b1;
      if (other_lane == lane_reg - 2'd1 && hit_near) left_flag <= 1'b1;
      if (other_lane == lane_reg + 2'd1 && hit_near) right_flag <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.decide) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_lane  <= lane_n;
      out_td    <= target_offset(lane_n);
      out_speed <= speed_n;
      out_ahead <= ahead_flag;
      out_left  <= left_flag;
      out_right <= right_flag;
    end
  end

  assign m_tdata = {3'b000, out_right, out_left, out_ahead, out_speed, out_td, out_lane};

  assign sts.root_done = root_done;
  assign sts.out_free  = !m_tvalid || m_tready;

endmodule

/* sv/lcsp_ctrl.sv */
// Controller state machine: sequences one transaction through the datapath.
// Depends on lcsp_pkg for the command and status structs.
module lcsp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tuser,
  output logic                s_tready,
  input  lcsp_pkg::lcsp_sts_t sts,
  output lcsp_pkg::lcsp_cmd_t cmd
);
  import lcsp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ1, ST_SQ2, ST_ROOT, ST_MUL, ST_DIV, ST_UPD, ST_DEC
  } state_t;

  state_t state;
  logic   accept;

  assign accept = s_tvalid && s_tready;

  // State and ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state    <= s_tuser ? ST_DEC : ST_SQ1;
            s_tready <= 1'b0;
          end
        end
        ST_SQ1:  state <= ST_SQ2;
        ST_SQ2:  state <= ST_ROOT;
        ST_ROOT: if (sts.root_done) state <= ST_MUL;
        ST_MUL:  state <= ST_DIV;
        ST_DIV:  state <= ST_UPD;
        ST_UPD: begin
          state    <= ST_IDLE;
          s_tready <= 1'b1;
        end
        ST_DEC: begin
          if (sts.out_free) begin
            state    <= ST_IDLE;
            s_tready <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd         = '0;
    cmd.load    = accept;
    cmd.sq1     = (state == ST_SQ1);
    cmd.root_go = (state == ST_SQ2);
    cmd.mul     = (state == ST_MUL);
    cmd.div     = (state == ST_DIV);
    cmd.upd     = (state == ST_UPD);
    cmd.decide  = (state == ST_DEC) && sts.out_free;
  end

endmodule

/* sv/lane_change_speed_planner_unit.sv */
// Lane change speed planner, top level: controller plus datapath.
// Depends on lcsp_pkg, lcsp_ctrl, lcsp_datapath (and lcsp_isqrt below it).
//
// Items are handled one at a time. A car report runs through these steps
// before the next transaction is accepted: vx is squared, vy^2 is added and
// the bit-serial square root unit is started and run to completion, and then
// prev_points * speed / FRAME_DIVISOR is formed (multiply, reciprocal
// estimate, correction and window compare). An end-of-frame item produces one
// result into the output register; a new item is accepted while that result
// waits, and an end-of-frame item only stalls if the previous result is still
// untaken. Report items produce no output. Configuration writes are taken at
// any time on cfg_we.
module lane_change_speed_planner_unit (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [lcsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcsp_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // ego_s[16:0], end_s[33:17], prev_points[39:34], other_d[50:40],
  // other_vx[62:51], other_vy[74:63], other_s[91:75], zero fill
  input  logic [lcsp_pkg::IN_TDATA_W-1:0]   s_tdata,
  // action: 0 car report, 1 end of frame
  input  logic                              s_tuser,
  // Result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // lane_out[1:0], target_d[9:2], ref_speed[25:10], blocked_ahead[26],
  // busy_left[27], busy_right[28], zero fill
  output logic [lcsp_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import lcsp_pkg::*;

  lcsp_cmd_t cmd;
  lcsp_sts_t sts;

  lcsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcsp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // A chosen lane is always one of the three lanes
  a_lane_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("lane_out out of range");

  // Target offset matches the lane it is reported with
  a_target_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[9:2] == target_offset(m_tdata[1:0])))
    else $error("target_d does not match lane_out");

  // The controller goes busy after every accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready held after accepted transaction");

  // A new result appears only while an end-of-frame item is in work
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without a pending end-of-frame item");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for lane_change_speed_planner_unit.
// A predictor of the lane and speed decisions runs beside the block and checks
// every result transaction. Depends on lcsp_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import lcsp_pkg::*;

  // Stream codes carried on s_tuser
  localparam logic ACT_REPORT = 1'b0;
  localparam logic ACT_DECIDE = 1'b1;

  // Index past the last register, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Result stream layout
  localparam int RES_LANE_LSB  = 0;
  localparam int RES_TD_LSB    = 2;
  localparam int RES_SPD_LSB   = 10;
  localparam int RES_AHEAD_BIT = 26;
  localparam int RES_LEFT_BIT  = 27;
  localparam int RES_RIGHT_BIT = 28;

  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 150;
  localparam int MAX_POS       = 131071;

  typedef struct packed {
    logic                    action;
    logic [POS_W-1:0]        ego_s;
    logic [POS_W-1:0]        end_s;
    logic [PREV_W-1:0]       prev;
    logic signed [D_W-1:0]   d;
    logic signed [V_W-1:0]   vx;
    logic signed [V_W-1:0]   vy;
    logic [POS_W-1:0]        os;
  } car_item_t;

  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic [TD_W-1:0]   td;
    logic [SPD_W-1:0]  speed;
    logic              ahead;
    logic              left;
    logic              right;
  } plan_t;

  typedef struct {
    car_item_t item;
    bit        typed;
    plan_t     want;
  } script_row_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Predictor state and its copy of the registers
  int plan_lane, plan_speed;
  bit occ_ahead, occ_left, occ_right;
  int cfg_gap, cfg_limit, cfg_mid, cfg_low, cfg_step_s, cfg_step_m, cfg_step_l;

  plan_t       expected_plans[$];
  plan_t       got_plan, exp_plan;
  script_row_t script[$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  lane_change_speed_planner_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("lane_change_speed_planner_unit regression: fail");
    $finish;
  end

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  // Floor square root, one result bit at a time from the top
  function automatic int unsigned root_floor(input int unsigned x);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 11; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // Advance the planner by one item; a decide item yields one plan
  function automatic void step_planner(input car_item_t it, output bit emits,
                                       output plan_t res);
    int ref_pos, dd, vxi, vyi, other_lane, chk, add, td_full;
    int unsigned spd;
    emits = 1'b0;
    res   = '0;
    if (it.action == ACT_REPORT) begin
      ref_pos = (it.prev != 0) ? int'(it.end_s) : int'(it.ego_s);
      dd  = $signed(it.d);
      vxi = $signed(it.vx);
      vyi = $signed(it.vy);
      // cars outside the three lanes are dropped
      if (dd >= 0 && dd < 3 * LANE_WIDTH) begin
        other_lane = dd / LANE_WIDTH;
        spd = root_floor(vxi * vxi + vyi * vyi);
        chk = int'(it.os) + int'(it.prev) * int'(spd) / FRAME_DIVISOR;
        if (other_lane == plan_lane) begin
          if (chk > ref_pos && chk < ref_pos + cfg_gap) occ_ahead = 1'b1;
        end else if (other_lane == plan_lane - 1) begin
          if (ref_pos - cfg_gap < chk && chk < ref_pos + cfg_gap) occ_left = 1'b1;
        end else if (other_lane == plan_lane + 1) begin
          if (ref_pos - cfg_gap < chk && chk < ref_pos + cfg_gap) occ_right = 1'b1;
        end
      end
    end else begin
      if (occ_ahead) begin
        if (!occ_left && plan_lane > int'(LANE_LEFT)) plan_lane--;
        else if (!occ_right && plan_lane < int'(LANE_RIGHT)) plan_lane++;
        else plan_speed = (plan_speed > cfg_step_m) ? plan_speed - cfg_step_m : 0;
      end else begin
        if ((plan_lane == int'(LANE_RIGHT) && !occ_left) ||
            (plan_lane == int'(LANE_LEFT) && !occ_right))
          plan_lane = int'(LANE_CENTER);
        // bands tested top down; a speed in no band is held
        add = 0;
        if (plan_speed < cfg_limit && plan_speed >= cfg_mid) add = cfg_step_s;
        else if (plan_speed < cfg_mid && plan_speed >= cfg_low) add = cfg_step_m;
        else if (plan_speed < cfg_low) add = cfg_step_l;
        plan_speed += add;
        if (plan_speed > 65535) plan_speed = 65535;
      end
      td_full   = LANE_WIDTH / 2 + LANE_WIDTH * plan_lane;
      res.lane  = plan_lane[LANE_W-1:0];
      res.td    = td_full[TD_W-1:0];
      res.speed = plan_speed[SPD_W-1:0];
      res.ahead = occ_ahead;
      res.left  = occ_left;
      res.right = occ_right;
      occ_ahead = 1'b0;
      occ_left  = 1'b0;
      occ_right = 1'b0;
      emits     = 1'b1;
    end
  endfunction

  function automatic car_item_t car(input int ego, input int endp, input int prev,
                                    input int d, input int vx, input int vy,
                                    input int os);
    car_item_t it;
    it.action = ACT_REPORT;
    it.ego_s  = ego[POS_W-1:0];
    it.end_s  = endp[POS_W-1:0];
    it.prev   = prev[PREV_W-1:0];
    it.d      = d[D_W-1:0];
    it.vx     = vx[V_W-1:0];
    it.vy     = vy[V_W-1:0];
    it.os     = os[POS_W-1:0];
    return it;
  endfunction

  function automatic car_item_t decide_item();
    car_item_t it;
    it = '0;
    it.action = ACT_DECIDE;
    return it;
  endfunction

  function automatic car_item_t noise_item();
    car_item_t it;
    it.action = ACT_REPORT;
    it.ego_s  = POS_W'($urandom);
    it.end_s  = POS_W'($urandom);
    it.prev   = PREV_W'($urandom);
    it.d      = D_W'($urandom);
    it.vx     = V_W'($urandom);
    it.vy     = V_W'($urandom);
    it.os     = POS_W'($urandom);
    return it;
  endfunction

  task automatic add_row(input car_item_t it, input bit typed, input plan_t want);
    script_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    script = {script, row};
  endtask

  // One input transaction; prediction runs at the accepting edge
  task automatic send_item(input car_item_t it, input bit typed, input plan_t want);
    logic [IN_TDATA_W-1:0] word;
    bit    emits;
    plan_t res;
    word = '0;
    word[EGO_LSB  +: POS_W]  = it.ego_s;
    word[END_LSB  +: POS_W]  = it.end_s;
    word[PREV_LSB +: PREV_W] = it.prev;
    word[D_LSB    +: D_W]    = it.d;
    word[VX_LSB   +: V_W]    = it.vx;
    word[VY_LSB   +: V_W]    = it.vy;
    word[OS_LSB   +: POS_W]  = it.os;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.action;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    step_planner(it, emits, res);
    if (emits) expected_plans = {expected_plans, (typed ? want : res)};
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_GAP_WINDOW:  cfg_gap    = int'(val[GAP_W-1:0]);
      REG_SPEED_LIMIT: cfg_limit  = int'(val);
      REG_MID_SPEED:   cfg_mid    = int'(val);
      REG_LOW_SPEED:   cfg_low    = int'(val);
      REG_STEP_SMALL:  cfg_step_s = int'(val[STEP_W-1:0]);
      REG_STEP_MID:    cfg_step_m = int'(val[STEP_W-1:0]);
      REG_STEP_LARGE:  cfg_step_l = int'(val[STEP_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [6:0][15:0] v);
    for (int i = 0; i < 7; i++) write_reg(i[CFG_IDX_W-1:0], v[i]);
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Wait for all results, then let any report still in flight finish
  task automatic settle();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (expected_plans.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_plans.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", expected_plans.size()));
      expected_plans.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Frames of reports near the own car, with noise and dropped decides
  task automatic run_traffic(input int quota);
    int sent, nrep, ref_pos, off, proj, vxi, vyi, osi;
    car_item_t it;
    logic [POS_W-1:0]  ego, endp;
    logic [PREV_W-1:0] prev;
    sent = 0;
    while (sent < quota) begin
      ego     = POS_W'($urandom);
      endp    = POS_W'($urandom);
      prev    = ($urandom_range(0, 3) == 0) ? '0 : PREV_W'($urandom);
      ref_pos = (prev != 0) ? int'(endp) : int'(ego);
      nrep    = $urandom_range(0, 8);
      repeat (nrep) begin
        it = noise_item();
        if ($urandom_range(0, 9) != 0) begin
          it.ego_s = ego;
          it.end_s = endp;
          it.prev  = prev;
          it.d = D_W'($urandom_range(0, 2) * LANE_WIDTH + $urandom_range(0, LANE_WIDTH - 1));
          if ($urandom_range(0, 1) != 0) begin
            vxi = int'($urandom_range(0, 127)) - 64;
            vyi = int'($urandom_range(0, 127)) - 64;
          end else begin
            vxi = int'($urandom_range(0, 4095)) - 2048;
            vyi = int'($urandom_range(0, 4095)) - 2048;
          end
          it.vx = vxi[V_W-1:0];
          it.vy = vyi[V_W-1:0];
          proj = int'(prev) * int'(root_floor(vxi * vxi + vyi * vyi)) / FRAME_DIVISOR;
          off  = int'($urandom_range(0, 2 * cfg_gap + 64)) - cfg_gap - 32;
          osi  = ref_pos + off - proj;
          if (osi < 0) osi = 0;
          if (osi > MAX_POS) osi = MAX_POS;
          it.os = osi[POS_W-1:0];
        end
        send_item(it, 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 19) != 0) begin
        it = noise_item();
        it.action = ACT_DECIDE;
        send_item(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Receiver back-pressure
  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // Result checker: every field against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_plan.lane  = m_tdata[RES_LANE_LSB +: LANE_W];
      got_plan.td    = m_tdata[RES_TD_LSB +: TD_W];
      got_plan.speed = m_tdata[RES_SPD_LSB +: SPD_W];
      got_plan.ahead = m_tdata[RES_AHEAD_BIT];
      got_plan.left  = m_tdata[RES_LEFT_BIT];
      got_plan.right = m_tdata[RES_RIGHT_BIT];
      if (expected_plans.size() == 0) begin
        note_failure($sformatf("unexpected result lane %0d td %0d speed %0d flags %b%b%b",
                               got_plan.lane, got_plan.td, got_plan.speed,
                               got_plan.ahead, got_plan.left, got_plan.right));
      end else begin
        exp_plan = expected_plans.pop_front();
        if (got_plan !== exp_plan)
          note_failure($sformatf({"mismatch: expected lane %0d td %0d speed %0d flags %b%b%b,",
                                  " got lane %0d td %0d speed %0d flags %b%b%b"},
                                 exp_plan.lane, exp_plan.td, exp_plan.speed,
                                 exp_plan.ahead, exp_plan.left, exp_plan.right,
                                 got_plan.lane, got_plan.td, got_plan.speed,
                                 got_plan.ahead, got_plan.left, got_plan.right));
      end
    end
  end

  initial begin
    logic [6:0][15:0] regs;
    int phase;

    // Predictor starts from the block's reset state
    plan_lane  = int'(LANE_CENTER);
    plan_speed = 0;
    occ_ahead  = 1'b0;
    occ_left   = 1'b0;
    occ_right  = 1'b0;
    cfg_gap    = 480;
    cfg_limit  = 49500;
    cfg_mid    = 30000;
    cfg_low    = 25000;
    cfg_step_s = 112;
    cfg_step_m = 224;
    cfg_step_l = 336;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under reset settings
    add_row(decide_item(), 1'b1, plan_t'{LANE_CENTER, 8'd96, 16'd336, 1'b0, 1'b0, 1'b0});
    add_row(car(1000, 0, 0, 96, 0, 0, 1100), 1'b0, '0);
    add_row(car(1000, 0, 0, 10, 0, 0, 1000), 1'b0, '0);
    add_row(decide_item(), 1'b1, plan_t'{LANE_RIGHT, 8'd160, 16'd336, 1'b1, 1'b1, 1'b0});
    add_row(decide_item(), 1'b1, plan_t'{LANE_CENTER, 8'd96, 16'd672, 1'b0, 1'b0, 1'b0});
    // cars in no lane, extreme field values
    add_row(car(MAX_POS, 0, 0, -1024, -2048, -2048, MAX_POS), 1'b0, '0);
    add_row(car(0, MAX_POS, 63, 1023, 2047, 2047, 0), 1'b0, '0);
    add_row(car(0, MAX_POS, 63, 192, 2047, -2048, 65536), 1'b0, '0);
    // full speed projection onto the right lane, end_s as reference
    add_row(car(2000, 5000, 63, 191, -2048, -2048, 1400), 1'b0, '0);
    add_row(car(2000, 5000, 63, 64, 0, 0, 5100), 1'b0, '0);
    add_row(car(5000, 5000, 0, 0, 2047, -2048, 5000), 1'b0, '0);
    add_row(decide_item(), 1'b1, plan_t'{LANE_CENTER, 8'd96, 16'd448, 1'b1, 1'b1, 1'b1});
    // window edges are exclusive
    add_row(car(1000, 1000, 0, 127, 0, 0, 1000), 1'b0, '0);
    add_row(car(1000, 1000, 0, 127, 0, 0, 1480), 1'b0, '0);
    add_row(car(1000, 1000, 0, 0, 0, 0, 520), 1'b0, '0);
    add_row(car(1000, 1000, 0, 128, 0, 0, 1479), 1'b0, '0);
    add_row(car(1000, 1000, 0, 127, 0, 0, 1001), 1'b0, '0);
    add_row(decide_item(), 1'b0, '0);
    // boxed in on the left lane: brake down to zero and hold there
    add_row(car(1000, 1000, 0, 63, 0, 0, 1001), 1'b0, '0);
    add_row(car(1000, 1000, 0, 64, 0, 0, 1000), 1'b0, '0);
    add_row(decide_item(), 1'b0, '0);
    add_row(car(1000, 1000, 0, 0, 0, 0, 1200), 1'b0, '0);
    add_row(car(1000, 1000, 0, 100, 0, 0, 900), 1'b0, '0);
    add_row(decide_item(), 1'b1, plan_t'{LANE_LEFT, 8'd32, 16'd0, 1'b1, 1'b0, 1'b1});
    add_row(car(1000, 1000, 0, 5, 0, 0, 1100), 1'b0, '0);
    add_row(car(1000, 1000, 0, 70, 0, 0, 1100), 1'b0, '0);
    add_row(decide_item(), 1'b0, '0);

    foreach (script[i]) send_item(script[i].item, script[i].typed, script[i].want);

    // Random phases, each under its own register setting and idle pattern
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          regs[REG_GAP_WINDOW] = 16'd480;   regs[REG_SPEED_LIMIT] = 16'd49500;
          regs[REG_MID_SPEED]  = 16'd30000; regs[REG_LOW_SPEED]   = 16'd25000;
          regs[REG_STEP_SMALL] = 16'd112;   regs[REG_STEP_MID]    = 16'd224;
          regs[REG_STEP_LARGE] = 16'd336;
        end
        1: regs = '0;
        2: regs = '1;
        3: begin
          // accelerate hard into saturation
          regs[REG_GAP_WINDOW] = 16'd480;   regs[REG_SPEED_LIMIT] = 16'hFFFF;
          regs[REG_MID_SPEED]  = 16'd0;     regs[REG_LOW_SPEED]   = 16'd0;
          regs[REG_STEP_SMALL] = 16'd1023;  regs[REG_STEP_MID]    = 16'd1023;
          regs[REG_STEP_LARGE] = 16'd1023;
        end
        4: begin
          // speed bands out of order
          regs[REG_GAP_WINDOW] = 16'd1200;  regs[REG_SPEED_LIMIT] = 16'd20000;
          regs[REG_MID_SPEED]  = 16'd40000; regs[REG_LOW_SPEED]   = 16'd60000;
          regs[REG_STEP_SMALL] = 16'd700;   regs[REG_STEP_MID]    = 16'd300;
          regs[REG_STEP_LARGE] = 16'd900;
        end
        default: for (int i = 0; i < 7; i++) regs[i] = 16'($urandom);
      endcase
      program_regs(regs);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      run_traffic(PHASE_ITEMS);
    end

    settle();
    if (mismatch_count == 0) $display("lane_change_speed_planner_unit regression: pass");
    else $display("lane_change_speed_planner_unit regression: fail");
    $finish;
  end

endmodule
